// ===== rtl/periodic_timer_table_top_defines.svh =====
// assertion macros for the periodic timer table checker
// expects clk and rst in the scope where a macro is used
`ifndef PERIODIC_TIMER_TABLE_TOP_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define PTT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("periodic timer table check failed");

// next-cycle implication, off during reset
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("periodic timer table check failed");

`endif

// ===== rtl/ptt_pkg.sv =====
// shared types and constants of the periodic timer table
// no dependencies
`default_nettype none

package ptt_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
  localparam int TIME_W     = 64;
  localparam int ID_W       = 8;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int STEP_W     = $clog2(TIME_W);

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIRE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd3;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    time_t           start;
    time_t           period;
    time_t           deadline;
  } entry_t;

  typedef struct packed {
    logic  start;
    time_t dividend;
    time_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    time_t rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_FIND_DONE,
    S_ADD_WR,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIRE_RD,
    S_FIRE_CHK,
    S_FIRE_OUT,
    S_FIRE_DIV,
    S_FIRE_WR,
    S_MIN_INIT,
    S_MIN_RD,
    S_MIN_CHK,
    S_FINAL
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/ptt_cmd_if.sv =====
// command channel of the periodic timer table
// uses ptt_pkg
`default_nettype none

interface ptt_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [ptt_pkg::OP_W-1:0]       operation;
  logic [ptt_pkg::ID_W-1:0]       timer_id;
  logic [ptt_pkg::TIME_W-1:0]     start_time;
  logic [ptt_pkg::TIME_W-1:0]     period;
  logic [ptt_pkg::TIME_W-1:0]     now;

  modport source (output valid, operation, timer_id, start_time, period, now,
                  input ready);
  modport sink (input valid, operation, timer_id, start_time, period, now,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/ptt_res_if.sv =====
// result channel of the periodic timer table
// uses ptt_pkg
`default_nettype none

interface ptt_res_if;
  logic                           valid;
  logic                           ready;
  logic                           fired;
  logic [ptt_pkg::ID_W-1:0]       fired_id;
  logic [ptt_pkg::TIME_W-1:0]     elapsed;
  logic [ptt_pkg::STATUS_W-1:0]   status;
  logic                           any_fired;
  logic [ptt_pkg::TIME_W-1:0]     earliest_deadline;
  logic [ptt_pkg::COUNT_W-1:0]    timer_count;
  logic                           last;

  modport source (output valid, fired, fired_id, elapsed, status, any_fired,
                  earliest_deadline, timer_count, last, input ready);
  modport sink (input valid, fired, fired_id, elapsed, status, any_fired,
                earliest_deadline, timer_count, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptt_rem.sv =====
// iterative restoring remainder unit, one quotient bit per cycle
// uses ptt_pkg
`default_nettype none

module ptt_rem (
  input  logic              clk,
  input  logic              rst,
  input  ptt_pkg::div_req_t req,
  output ptt_pkg::div_rsp_t rsp
);

  ptt_pkg::time_t             rem;
  ptt_pkg::time_t             dvd;
  ptt_pkg::time_t             dsr;
  logic [ptt_pkg::STEP_W-1:0] step;
  logic                       busy;
  logic                       done;
  logic [ptt_pkg::TIME_W:0]   trial;
  logic [ptt_pkg::TIME_W:0]   diff;

  assign trial = {rem, dvd[ptt_pkg::TIME_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (step == ptt_pkg::STEP_W'(ptt_pkg::TIME_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      dvd  <= req.dividend;
      dsr  <= req.divisor;
      step <= '0;
    end else if (busy) begin
      // partial remainder stays below the divisor, so the top bit drops
      if (!diff[ptt_pkg::TIME_W]) begin
        rem <= diff[ptt_pkg::TIME_W-1:0];
      end else begin
        rem <= trial[ptt_pkg::TIME_W-1:0];
      end
      dvd  <= {dvd[ptt_pkg::TIME_W-2:0], 1'b0};
      step <= step + ptt_pkg::STEP_W'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

// ===== rtl/periodic_timer_table_top.sv =====
// top level of the periodic timer table: sequencer, entry memory, result register
// uses ptt_pkg, ptt_cmd_if, ptt_res_if and ptt_rem
`default_nettype none

// The block holds up to 16 periodic timers in an ordered table and takes one
// item at a time on cmd; cmd.ready is high only while the sequencer is idle.
// Every item ends with one result marked last, and a fire item first sends
// one result per due timer in table order. The table sits in a small memory
// with one write and one registered read port, so every table visit takes a
// read state and then a check or write state; after each operation the table
// is walked once more for the earliest deadline. Each due timer in a fire
// issues its result, runs the shared 64-step remainder unit and then writes
// its new deadline. Results go through a one-deep output register; the
// sequencer only waits on res.ready when that register is still full.

module periodic_timer_table_top (
  input  logic      clk,
  input  logic      rst,
  ptt_cmd_if.sink   cmd,
  ptt_res_if.source res
);

  // control state
  ptt_pkg::state_t state, state_next;
  ptt_pkg::cnt_t   count;
  logic            res_valid;

  // latched command
  logic [ptt_pkg::OP_W-1:0]     c_op;
  logic [ptt_pkg::ID_W-1:0]     c_id;
  ptt_pkg::time_t               c_start;
  ptt_pkg::time_t               c_period;
  ptt_pkg::time_t               c_now;

  // per-item working registers
  logic [ptt_pkg::STATUS_W-1:0] status;
  logic                         any;
  logic                         found;
  ptt_pkg::idx_t                idx;
  ptt_pkg::time_t               best;

  // result register payload
  logic                         r_fired;
  logic [ptt_pkg::ID_W-1:0]     r_id;
  ptt_pkg::time_t               r_elapsed;
  logic [ptt_pkg::STATUS_W-1:0] r_status;
  logic                         r_any;
  ptt_pkg::time_t               r_earliest;
  logic [ptt_pkg::COUNT_W-1:0]  r_count;
  logic                         r_last;

  // entry memory
  ptt_pkg::entry_t mem [ptt_pkg::MAX_TIMERS];
  ptt_pkg::entry_t rdata;
  ptt_pkg::idx_t   rd_addr;
  ptt_pkg::idx_t   wr_addr;
  ptt_pkg::entry_t wr_data;
  logic            mem_we;

  ptt_pkg::div_req_t div_req;
  ptt_pkg::div_rsp_t div_rsp;

  logic accept;
  logic out_free;
  logic at_last;
  logic due;
  logic shift_end;
  logic load_fire;
  logic load_final;

  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !res_valid || res.ready;
  // idx points at the last live entry
  assign at_last   = (ptt_pkg::CNT_W'(idx) + ptt_pkg::CNT_W'(1)) == count;
  assign shift_end = (ptt_pkg::CNT_W'(idx) + ptt_pkg::CNT_W'(1)) >= count;
  // strictly past its deadline
  assign due       = c_now > rdata.deadline;

  assign cmd.ready = (state == ptt_pkg::S_IDLE);

  ptt_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ptt_pkg::S_IDLE: begin
        if (accept) begin
          if ((cmd.operation == ptt_pkg::OP_ADD) ||
              (cmd.operation == ptt_pkg::OP_REMOVE)) begin
            state_next = (count == '0) ? ptt_pkg::S_FIND_DONE : ptt_pkg::S_FIND_RD;
          end else if (cmd.operation == ptt_pkg::OP_FIRE) begin
            state_next = (count == '0) ? ptt_pkg::S_MIN_INIT : ptt_pkg::S_FIRE_RD;
          end else begin
            state_next = ptt_pkg::S_MIN_INIT;
          end
        end
      end
      ptt_pkg::S_FIND_RD:  state_next = ptt_pkg::S_FIND_CHK;
      ptt_pkg::S_FIND_CHK: begin
        if ((rdata.id == c_id) || at_last) begin
          state_next = ptt_pkg::S_FIND_DONE;
        end else begin
          state_next = ptt_pkg::S_FIND_RD;
        end
      end
      ptt_pkg::S_FIND_DONE: begin
        if (c_op == ptt_pkg::OP_ADD) begin
          if (found || (count == ptt_pkg::CNT_W'(ptt_pkg::MAX_TIMERS)) ||
              (c_period == '0)) begin
            state_next = ptt_pkg::S_MIN_INIT;
          end else begin
            state_next = ptt_pkg::S_ADD_WR;
          end
        end else begin
          state_next = found ? ptt_pkg::S_SHIFT_RD : ptt_pkg::S_MIN_INIT;
        end
      end
      ptt_pkg::S_ADD_WR:   state_next = ptt_pkg::S_MIN_INIT;
      ptt_pkg::S_SHIFT_RD: state_next = shift_end ? ptt_pkg::S_MIN_INIT : ptt_pkg::S_SHIFT_WR;
      ptt_pkg::S_SHIFT_WR: state_next = ptt_pkg::S_SHIFT_RD;
      ptt_pkg::S_FIRE_RD:  state_next = ptt_pkg::S_FIRE_CHK;
      ptt_pkg::S_FIRE_CHK: begin
        if (due) begin
          state_next = ptt_pkg::S_FIRE_OUT;
        end else begin
          state_next = at_last ? ptt_pkg::S_MIN_INIT : ptt_pkg::S_FIRE_RD;
        end
      end
      ptt_pkg::S_FIRE_OUT: state_next = out_free ? ptt_pkg::S_FIRE_DIV : ptt_pkg::S_FIRE_OUT;
      ptt_pkg::S_FIRE_DIV: state_next = div_rsp.done ? ptt_pkg::S_FIRE_WR : ptt_pkg::S_FIRE_DIV;
      ptt_pkg::S_FIRE_WR:  state_next = at_last ? ptt_pkg::S_MIN_INIT : ptt_pkg::S_FIRE_RD;
      ptt_pkg::S_MIN_INIT: state_next = (count == '0) ? ptt_pkg::S_FINAL : ptt_pkg::S_MIN_RD;
      ptt_pkg::S_MIN_RD:   state_next = ptt_pkg::S_MIN_CHK;
      ptt_pkg::S_MIN_CHK:  state_next = at_last ? ptt_pkg::S_FINAL : ptt_pkg::S_MIN_RD;
      ptt_pkg::S_FINAL:    state_next = out_free ? ptt_pkg::S_IDLE : ptt_pkg::S_FINAL;
      default:             state_next = ptt_pkg::S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    rd_addr          = idx;
    mem_we           = 1'b0;
    wr_addr          = idx;
    wr_data          = rdata;
    load_fire        = 1'b0;
    load_final       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = rdata.deadline - rdata.start;
    div_req.divisor  = rdata.period;
    unique case (state)
      ptt_pkg::S_ADD_WR: begin
        mem_we           = 1'b1;
        wr_addr          = ptt_pkg::IDX_W'(count);
        wr_data.id       = c_id;
        wr_data.start    = c_start;
        wr_data.period   = c_period;
        wr_data.deadline = c_start;
      end
      // compaction reads the entry behind the one it overwrites
      ptt_pkg::S_SHIFT_RD: rd_addr = idx + ptt_pkg::IDX_W'(1);
      ptt_pkg::S_SHIFT_WR: mem_we = 1'b1;
      ptt_pkg::S_FIRE_OUT: begin
        load_fire     = out_free;
        div_req.start = out_free;
      end
      ptt_pkg::S_FIRE_WR: begin
        // start + (q + 1) * period == deadline - rem + period
        mem_we           = (rdata.period != '0);
        wr_data.deadline = rdata.deadline - div_rsp.rem + rdata.period;
      end
      ptt_pkg::S_FINAL: load_final = out_free;
      default: begin
      end
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptt_pkg::S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ptt_pkg::S_ADD_WR) begin
        count <= count + ptt_pkg::CNT_W'(1);
      end else if ((state == ptt_pkg::S_SHIFT_RD) && shift_end) begin
        count <= count - ptt_pkg::CNT_W'(1);
      end
      if (load_fire || load_final) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ptt_pkg::S_IDLE: begin
        if (accept) begin
          c_op     <= cmd.operation;
          c_id     <= cmd.timer_id;
          c_start  <= cmd.start_time;
          c_period <= cmd.period;
          c_now    <= cmd.now;
          status   <= ptt_pkg::ST_OK;
          any      <= 1'b0;
          found    <= 1'b0;
          idx      <= '0;
          best     <= '1;
        end
      end
      ptt_pkg::S_FIND_CHK: begin
        // on a match idx stays at the matching slot
        if (rdata.id == c_id) begin
          found <= 1'b1;
        end else if (!at_last) begin
          idx <= idx + ptt_pkg::IDX_W'(1);
        end
      end
      ptt_pkg::S_FIND_DONE: begin
        if (c_op == ptt_pkg::OP_ADD) begin
          priority if (found) begin
            status <= ptt_pkg::ST_NOTFOUND;
          end else if (count == ptt_pkg::CNT_W'(ptt_pkg::MAX_TIMERS)) begin
            status <= ptt_pkg::ST_FULL;
          end else if (c_period == '0) begin
            status <= ptt_pkg::ST_ZERO;
          end else begin
            status <= ptt_pkg::ST_OK;
          end
        end else if (!found) begin
          status <= ptt_pkg::ST_NOTFOUND;
        end
      end
      ptt_pkg::S_SHIFT_WR: idx <= idx + ptt_pkg::IDX_W'(1);
      ptt_pkg::S_FIRE_CHK: begin
        if (!due && !at_last) begin
          idx <= idx + ptt_pkg::IDX_W'(1);
        end
      end
      ptt_pkg::S_FIRE_OUT: begin
        if (out_free) begin
          any <= 1'b1;
        end
      end
      ptt_pkg::S_FIRE_WR: begin
        if (!at_last) begin
          idx <= idx + ptt_pkg::IDX_W'(1);
        end
      end
      ptt_pkg::S_MIN_INIT: idx <= '0;
      ptt_pkg::S_MIN_CHK: begin
        if (rdata.deadline < best) begin
          best <= rdata.deadline;
        end
        if (!at_last) begin
          idx <= idx + ptt_pkg::IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (load_fire) begin
      r_fired    <= 1'b1;
      r_id       <= rdata.id;
      r_elapsed  <= c_now - rdata.start;
      r_status   <= ptt_pkg::ST_OK;
      r_any      <= 1'b0;
      r_earliest <= '0;
      r_count    <= '0;
      r_last     <= 1'b0;
    end else if (load_final) begin
      r_fired    <= 1'b0;
      r_id       <= '0;
      r_elapsed  <= '0;
      r_status   <= status;
      r_any      <= any;
      r_earliest <= best;
      r_count    <= ptt_pkg::COUNT_W'(count);
      r_last     <= 1'b1;
    end
  end

  assign res.valid             = res_valid;
  assign res.fired             = r_fired;
  assign res.fired_id          = r_id;
  assign res.elapsed           = r_elapsed;
  assign res.status            = r_status;
  assign res.any_fired         = r_any;
  assign res.earliest_deadline = r_earliest;
  assign res.timer_count       = r_count;
  assign res.last              = r_last;

endmodule

`default_nettype wire

// ===== rtl/ptt_chk.sv =====
// port-level checks of the periodic timer table, bound to the top level
// uses ptt_pkg and periodic_timer_table_top_defines.svh
`default_nettype none
`include "periodic_timer_table_top_defines.svh"

module ptt_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            cmd_valid,
  input logic                            cmd_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic                            res_fired,
  input logic [ptt_pkg::STATUS_W-1:0]    res_status,
  input logic [ptt_pkg::TIME_W-1:0]      res_earliest_deadline,
  input logic [ptt_pkg::COUNT_W-1:0]     res_timer_count,
  input logic                            res_last
);

  // a pending result is held until taken
  `PTT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
  // an accepted item takes the block out of idle, so cmd_ready drops
  `PTT_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)
  // per-timer results are never final and carry no error
  `PTT_ASSERT_IMPLY(a_fired_not_last, res_valid && res_fired,
                    !res_last && (res_status == ptt_pkg::ST_OK))
  // an empty table reports no deadline
  `PTT_ASSERT_IMPLY(a_empty_no_deadline,
                    res_valid && res_last && (res_timer_count == '0),
                    res_earliest_deadline == '1)

endmodule

bind periodic_timer_table_top ptt_chk u_ptt_chk (
  .clk                   (clk),
  .rst                   (rst),
  .cmd_valid             (cmd.valid),
  .cmd_ready             (cmd.ready),
  .res_valid             (res.valid),
  .res_ready             (res.ready),
  .res_fired             (res.fired),
  .res_status            (res.status),
  .res_earliest_deadline (res.earliest_deadline),
  .res_timer_count       (res.timer_count),
  .res_last              (res.last)
);

`default_nettype wire

// ===== test/ptt_tb_if.sv =====
// no separate interfaces needed: the testbench uses the block's own ptt_cmd_if and ptt_res_if
// this file holds the shared item types of the testbench; depends on ptt_pkg
`timescale 1ns / 1ps
`default_nettype none

package ptt_tb_pkg;
  import ptt_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [ID_W-1:0]     timer_id;
    time_t               start_time;
    time_t               period;
    time_t               now;
  } cmd_item_t;

  typedef struct packed {
    logic                fired;
    logic [ID_W-1:0]     fired_id;
    time_t               elapsed;
    logic [STATUS_W-1:0] status;
    logic                any_fired;
    time_t               earliest_deadline;
    logic [COUNT_W-1:0]  timer_count;
    logic                last;
  } res_item_t;
endpackage

`default_nettype wire

// ===== test/tb.sv =====
// testbench of the periodic timer table: directed and random add, remove and fire
// items, with an own model of the table predicting every result
// depends on ptt_pkg, ptt_tb_pkg, ptt_cmd_if, ptt_res_if and the block's rtl
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import ptt_pkg::*;
  import ptt_tb_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam int HOLD_OFF_LEN = 400;

  logic clk;
  logic rst;

  ptt_cmd_if cmd ();
  ptt_res_if res ();

  periodic_timer_table_top i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  // own copy of the timer table
  logic [ID_W-1:0] tbl_id [MAX_TIMERS];
  time_t           tbl_start [MAX_TIMERS];
  time_t           tbl_period [MAX_TIMERS];
  time_t           tbl_deadline [MAX_TIMERS];
  int              tbl_count;

  res_item_t       expected_results [$];
  int              errors = 0;
  longint unsigned cycle;

  // idling mode: sender gap and receiver stall, percent
  int              send_idle_pct;
  int              recv_stall_pct;
  // hold-off requests from the tests, served by the receiver
  int              hold_off_reqs;
  int              hold_off_seen;
  int              hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // cycle counter and timeout
  initial begin
    cycle = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic int find_timer(logic [ID_W-1:0] id);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  // predicts the results of one item and advances the table
  task automatic predict_timer_step(cmd_item_t c);
    res_item_t r;
    int pos;
    logic [STATUS_W-1:0] st;
    logic any;
    time_t best;
    time_t calls;
    st = ST_OK;
    any = 1'b0;
    if (c.operation == OP_ADD) begin
      if (find_timer(c.timer_id) >= 0) st = ST_NOTFOUND;
      else if (tbl_count >= MAX_TIMERS) st = ST_FULL;
      else if (c.period == 0) st = ST_ZERO;
      else begin
        tbl_id[tbl_count] = c.timer_id;
        tbl_start[tbl_count] = c.start_time;
        tbl_period[tbl_count] = c.period;
        tbl_deadline[tbl_count] = c.start_time;
        tbl_count++;
      end
    end else if (c.operation == OP_REMOVE) begin
      pos = find_timer(c.timer_id);
      if (pos < 0) st = ST_NOTFOUND;
      else begin
        for (int i = pos; i + 1 < tbl_count; i++) begin
          tbl_id[i] = tbl_id[i+1];
          tbl_start[i] = tbl_start[i+1];
          tbl_period[i] = tbl_period[i+1];
          tbl_deadline[i] = tbl_deadline[i+1];
        end
        tbl_count--;
      end
    end else if (c.operation == OP_FIRE) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (c.now > tbl_deadline[i]) begin
          r = '0;
          r.fired = 1'b1;
          r.fired_id = tbl_id[i];
          r.elapsed = c.now - tbl_start[i];
          expected_results.insert(expected_results.size(), r);
          any = 1'b1;
          calls = (tbl_deadline[i] - tbl_start[i]) / tbl_period[i] + 64'd1;
          tbl_deadline[i] = tbl_start[i] + calls * tbl_period[i];
        end
      end
    end
    best = '1;
    for (int i = 0; i < tbl_count; i++)
      if (tbl_deadline[i] < best) best = tbl_deadline[i];
    r = '0;
    r.status = st;
    r.any_fired = any;
    r.earliest_deadline = best;
    r.timer_count = tbl_count[COUNT_W-1:0];
    r.last = 1'b1;
    expected_results.insert(expected_results.size(), r);
  endtask

  // sends one item, with a random gap before it per the idling mode
  task automatic send_item(cmd_item_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid      <= 1'b1;
    cmd.operation  <= c.operation;
    cmd.timer_id   <= c.timer_id;
    cmd.start_time <= c.start_time;
    cmd.period     <= c.period;
    cmd.now        <= c.now;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    // accepted at this edge: predict now, before any result can come back
    // valid stays up until the next gap or drain, or carries the next item
    predict_timer_step(c);
  endtask

  task automatic drain_results();
    cmd.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold_off_seen <= 0;
      hold_off_cycles <= 0;
    end else if (hold_off_seen != hold_off_reqs) begin
      hold_off_seen <= hold_off_reqs;
      hold_off_cycles <= HOLD_OFF_LEN - 1;
      res.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // checker: compares every accepted result with the oldest expectation
  always @(posedge clk) begin
    res_item_t got;
    res_item_t exp_r;
    if (!rst && res.valid && res.ready) begin
      got.fired = res.fired;
      got.fired_id = res.fired_id;
      got.elapsed = res.elapsed;
      got.status = res.status;
      got.any_fired = res.any_fired;
      got.earliest_deadline = res.earliest_deadline;
      got.timer_count = res.timer_count;
      got.last = res.last;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result %p", $realtime, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t mismatch expected %p actual %p", $realtime, exp_r, got);
          errors++;
        end
      end
    end
  end

  function automatic cmd_item_t make_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                          time_t st, time_t per, time_t nw);
    cmd_item_t c;
    c.operation = op;
    c.timer_id = id;
    c.start_time = st;
    c.period = per;
    c.now = nw;
    return c;
  endfunction

  function automatic time_t rand_time();
    return {$urandom(), $urandom()};
  endfunction

  // directed: empty fire, errors, full table, wrapping, extremes, no-op
  task automatic test_directed();
    send_item(make_item(OP_FIRE, 8'd0, '0, '0, '1));
    send_item(make_item(OP_REMOVE, 8'd5, '0, '0, '0));
    send_item(make_item(OP_NOP, 8'hff, '1, '1, '1));
    send_item(make_item(OP_ADD, 8'd1, 64'd0, 64'd0, '0));
    send_item(make_item(OP_ADD, 8'd0, 64'd0, 64'd1, '0));
    send_item(make_item(OP_ADD, 8'd0, 64'd9, 64'd9, '0));
    send_item(make_item(OP_ADD, 8'hff, '1, '1, '0));
    send_item(make_item(OP_ADD, 8'd7, 64'hffff_ffff_ffff_fff0, 64'h10, '0));
    send_item(make_item(OP_FIRE, 8'd0, '0, '0, 64'd0));
    send_item(make_item(OP_FIRE, 8'd0, '0, '0, '1));
    send_item(make_item(OP_FIRE, 8'd0, '0, '0, '1));
    send_item(make_item(OP_REMOVE, 8'd0, '0, '0, '0));
    for (int i = 0; i < 15; i++)
      send_item(make_item(OP_ADD, 8'(8'h20 + i), 64'(i * 3), 64'(i + 1), '0));
    send_item(make_item(OP_ADD, 8'h40, '0, 64'd1, '0));
    send_item(make_item(OP_FIRE, 8'd0, '0, '0, 64'd100));
    send_item(make_item(OP_REMOVE, 8'hff, '0, '0, '0));
  endtask

  // random: mostly adds of fresh ids, removes of present ids and fires at mostly small times
  task automatic test_random(int n);
    cmd_item_t c;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      c = make_item(OP_NOP, 8'($urandom()), rand_time(), rand_time(), rand_time());
      if (k < 35) begin
        c.operation = OP_ADD;
        if ($urandom_range(3) != 0) begin
          c.start_time = 64'($urandom_range(1000));
          c.period = 64'($urandom_range(50, 1));
        end
        if ($urandom_range(19) == 0) c.period = '0;
        if (tbl_count > 0 && $urandom_range(9) == 0)
          c.timer_id = tbl_id[$urandom_range(tbl_count - 1)];
      end else if (k < 60) begin
        c.operation = OP_REMOVE;
        if (tbl_count > 0 && $urandom_range(4) != 0)
          c.timer_id = tbl_id[$urandom_range(tbl_count - 1)];
      end else if (k < 97) begin
        c.operation = OP_FIRE;
        if ($urandom_range(3) != 0) c.now = 64'($urandom_range(1500));
      end
      send_item(c);
    end
  endtask

  // long receiver hold-off while items keep coming, then a pause until idle
  task automatic test_backpressure();
    hold_off_reqs++;
    for (int i = 0; i < 6; i++)
      send_item(make_item(OP_FIRE, 8'd0, '0, '0, rand_time()));
    drain_results();
  endtask

  initial begin
    cmd.valid = 1'b0;
    cmd.operation = OP_NOP;
    cmd.timer_id = '0;
    cmd.start_time = '0;
    cmd.period = '0;
    cmd.now = '0;
    rst = 1'b1;
    tbl_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_reqs = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(40);
    drain_results();
    send_idle_pct = 83;
    test_random(45);
    send_idle_pct = 0;
    recv_stall_pct = 83;
    test_random(45);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    test_random(45);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    test_random(20);

    drain_results();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

`default_nettype wire
